[src/dils_pkg.sv]
package dils_pkg;

  // Native panel geometry (portrait)
  localparam int NATIVE_WIDTH  = 240;
  localparam int NATIVE_HEIGHT = 320;

  // Panel dimensions as carried on the result port
  localparam logic [8:0] PANEL_W = 9'(NATIVE_WIDTH);
  localparam logic [8:0] PANEL_H = 9'(NATIVE_HEIGHT);

  // Walker phases
  localparam logic [1:0] PH_CMD   = 2'd0;
  localparam logic [1:0] PH_COUNT = 2'd1;
  localparam logic [1:0] PH_ARGS  = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_CMD   = 2'd0;
  localparam logic [1:0] KIND_PARAM = 2'd1;
  localparam logic [1:0] KIND_DELAY = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_SHORT_DELAY = 3'd0;
  localparam logic [2:0] REG_LONG_DELAY  = 3'd1;
  localparam logic [2:0] REG_ACCESS_CTRL = 3'd2;
  localparam logic [2:0] REG_SLEEP_OUT   = 3'd3;
  localparam logic [2:0] REG_DISPLAY_ON  = 3'd4;

  // Count byte layout
  localparam int COUNT_DELAY_BIT = 7;
  localparam int SWAP_BIT        = 5;

  // Result queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] short_delay_ms;
    logic [7:0] long_delay_ms;
    logic [7:0] access_control_code;
    logic [7:0] sleep_out_code;
    logic [7:0] display_on_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] held_command;
    logic [6:0] args_left;
    logic       first_arg_pending;
    logic       delay_wanted;
    logic       axes_swapped;
  } walk_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] bus_byte;
    logic [7:0] delay_ms;
    logic [8:0] panel_width;
    logic [8:0] panel_height;
    logic       last_of_run;
  } result_t;

endpackage

[src/dils_decode.sv]
module dils_decode (
  input  dils_pkg::cfg_t        cfg_i,
  input  dils_pkg::walk_state_t state_i,
  input  logic [7:0]            table_byte_i,
  output dils_pkg::walk_state_t state_o,
  output dils_pkg::result_t     res0_o,
  output dils_pkg::result_t     res1_o,
  output logic [1:0]            count_o
);

  logic [7:0] chosen_delay;
  logic [6:0] args_dec;
  logic [6:0] args_new;
  logic       delay_new;
  logic [1:0] kind0;
  logic [1:0] kind1;
  logic [7:0] byte0;
  logic [7:0] delay0;
  logic [7:0] delay1;
  logic [8:0] dim_w;
  logic [8:0] dim_h;

  // Pick the long delay for sleep-out and display-on
  assign chosen_delay = (state_i.held_command == cfg_i.sleep_out_code ||
                         state_i.held_command == cfg_i.display_on_code) ?
                        cfg_i.long_delay_ms : cfg_i.short_delay_ms;

  assign args_dec  = state_i.args_left - 7'd1;
  assign args_new  = table_byte_i[6:0];
  assign delay_new = table_byte_i[dils_pkg::COUNT_DELAY_BIT];

  // Advance the walker and build up to two results
  always_comb begin
    state_o = state_i;
    count_o = 2'd0;
    kind0   = dils_pkg::KIND_CMD;
    kind1   = dils_pkg::KIND_DELAY;
    byte0   = 8'd0;
    delay0  = 8'd0;
    delay1  = 8'd0;
    case (state_i.phase)
      dils_pkg::PH_CMD: begin
        count_o = 2'd1;
        if (table_byte_i == 8'd0) begin
          state_o.phase = dils_pkg::PH_DONE;
          kind0         = dils_pkg::KIND_END;
        end else begin
          state_o.held_command = table_byte_i;
          state_o.phase        = dils_pkg::PH_COUNT;
          kind0                = dils_pkg::KIND_CMD;
          byte0                = table_byte_i;
        end
      end
      dils_pkg::PH_COUNT: begin
        state_o.args_left    = args_new;
        state_o.delay_wanted = delay_new;
        if (args_new == 7'd0) begin
          state_o.first_arg_pending = 1'b0;
          state_o.phase             = dils_pkg::PH_CMD;
          if (delay_new) begin
            count_o              = 2'd1;
            kind0                = dils_pkg::KIND_DELAY;
            delay0               = chosen_delay;
            state_o.delay_wanted = 1'b0;
          end
        end else begin
          state_o.first_arg_pending =
            (state_i.held_command == cfg_i.access_control_code);
          state_o.phase = dils_pkg::PH_ARGS;
        end
      end
      dils_pkg::PH_ARGS: begin
        if (state_i.first_arg_pending) begin
          state_o.axes_swapped      = table_byte_i[dils_pkg::SWAP_BIT];
          state_o.first_arg_pending = 1'b0;
        end
        count_o           = 2'd1;
        kind0             = dils_pkg::KIND_PARAM;
        byte0             = table_byte_i;
        state_o.args_left = args_dec;
        if (args_dec == 7'd0) begin
          state_o.phase = dils_pkg::PH_CMD;
          if (state_i.delay_wanted) begin
            count_o              = 2'd2;
            delay1               = chosen_delay;
            state_o.delay_wanted = 1'b0;
          end
        end
      end
      default: begin
        // table ended: drop the byte
      end
    endcase
  end

  // Dimensions follow the orientation left by this byte
  assign dim_w = state_o.axes_swapped ? dils_pkg::PANEL_H : dils_pkg::PANEL_W;
  assign dim_h = state_o.axes_swapped ? dils_pkg::PANEL_W : dils_pkg::PANEL_H;

  always_comb begin
    res0_o.kind         = kind0;
    res0_o.bus_byte     = byte0;
    res0_o.delay_ms     = delay0;
    res0_o.panel_width  = dim_w;
    res0_o.panel_height = dim_h;
    res0_o.last_of_run  = (count_o == 2'd1);
    res1_o.kind         = kind1;
    res1_o.bus_byte     = 8'd0;
    res1_o.delay_ms     = delay1;
    res1_o.panel_width  = dim_w;
    res1_o.panel_height = dim_h;
    res1_o.last_of_run  = 1'b1;
  end

endmodule

[src/dils_queue.sv]
module dils_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_cnt_i,
  input  dils_pkg::result_t   push0_i,
  input  dils_pkg::result_t   push1_i,
  input  logic                pop_i,
  output dils_pkg::result_t   head_o,
  output logic                not_empty_o,
  output logic                room_two_o
);

  localparam int CW = dils_pkg::QUEUE_AW + 1;

  dils_pkg::result_t                entry_q [dils_pkg::QUEUE_DEPTH];
  logic [dils_pkg::QUEUE_AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [dils_pkg::QUEUE_AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]                    fill_q, fill_d;
  logic [dils_pkg::QUEUE_AW-1:0]    wr_ptr_nx;

  assign wr_ptr_nx   = wr_ptr_q + 1'b1;
  assign head_o      = entry_q[rd_ptr_q];
  assign not_empty_o = (fill_q != '0);
  assign room_two_o  = (fill_q <= CW'(dils_pkg::QUEUE_DEPTH - 2));

  // Move pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q + dils_pkg::QUEUE_AW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + dils_pkg::QUEUE_AW'(pop_i);
    fill_d   = fill_q + CW'(push_cnt_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store incoming results in order
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      entry_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      entry_q[wr_ptr_nx] <= push1_i;
    end
  end

endmodule

[src/display_init_list_sequencer.sv]
// Display init table sequencer. Feed the init table one byte per transaction
// on the input channel: records of command byte, count byte (bit 7 asks for a
// delay, bits 6..0 give the argument count) and arguments, closed by a zero
// command byte. Each command, argument, delay and the end marker leave as one
// transaction on the output channel, with the current panel width and height
// and last_of_run marking the final result of each input byte. After the end
// marker bytes are taken and dropped until reset. One input byte is taken per
// clock while the queue has room; a last argument byte that also asks for a
// delay produces two results. Results pass through a four-entry queue, and the
// input stalls whenever fewer than two queue entries are free.
// Write the configuration registers only while the block is idle.
module display_init_list_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] table_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] bus_byte_o,
  output logic [7:0] delay_ms_o,
  output logic [8:0] panel_width_o,
  output logic [8:0] panel_height_o,
  output logic       last_of_run_o
);

  dils_pkg::cfg_t        cfg_q;
  dils_pkg::walk_state_t state_q, state_d, state_nx;
  dils_pkg::result_t     res0, res1, head;
  logic [1:0]            res_cnt;
  logic [1:0]            push_cnt;
  logic                  in_take;
  logic                  out_take;
  logic                  room_two;
  logic                  not_empty;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_delay_ms      <= 8'd5;
      cfg_q.long_delay_ms       <= 8'd120;
      cfg_q.access_control_code <= 8'h36;
      cfg_q.sleep_out_code      <= 8'h11;
      cfg_q.display_on_code     <= 8'h29;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dils_pkg::REG_SHORT_DELAY: cfg_q.short_delay_ms      <= cfg_data_i;
        dils_pkg::REG_LONG_DELAY:  cfg_q.long_delay_ms       <= cfg_data_i;
        dils_pkg::REG_ACCESS_CTRL: cfg_q.access_control_code <= cfg_data_i;
        dils_pkg::REG_SLEEP_OUT:   cfg_q.sleep_out_code      <= cfg_data_i;
        dils_pkg::REG_DISPLAY_ON:  cfg_q.display_on_code     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Handshakes
  assign in_stall_o = !room_two;
  assign in_take    = in_valid_i && room_two;
  assign out_take   = not_empty && !out_stall_i;

  dils_decode u_decode (
    .cfg_i        (cfg_q),
    .state_i      (state_q),
    .table_byte_i (table_byte_i),
    .state_o      (state_nx),
    .res0_o       (res0),
    .res1_o       (res1),
    .count_o      (res_cnt)
  );

  // Advance the walker only on an accepted transaction
  assign state_d  = in_take ? state_nx : state_q;
  assign push_cnt = in_take ? res_cnt : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase             <= dils_pkg::PH_CMD;
      state_q.held_command      <= 8'd0;
      state_q.args_left         <= 7'd0;
      state_q.first_arg_pending <= 1'b0;
      state_q.delay_wanted      <= 1'b0;
      state_q.axes_swapped      <= 1'b0;
    end else begin
      state_q <= state_d;
    end
  end

  dils_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push0_i     (res0),
    .push1_i     (res1),
    .pop_i       (out_take),
    .head_o      (head),
    .not_empty_o (not_empty),
    .room_two_o  (room_two)
  );

  // Drive the output channel from the queue head
  assign out_valid_o    = not_empty;
  assign kind_o         = head.kind;
  assign bus_byte_o     = head.bus_byte;
  assign delay_ms_o     = head.delay_ms;
  assign panel_width_o  = head.panel_width;
  assign panel_height_o = head.panel_height;
  assign last_of_run_o  = head.last_of_run;

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int         MAX_WAIT       = 13;
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         QUIET_LIMIT    = 1000;
  localparam int         PHASE_BYTES    = 62;
  localparam int         PHASE_COUNT    = 6;
  localparam logic [7:0] TABLE_END_BYTE = 8'h00;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       cfg_we_i     = 1'b0;
  logic [2:0] cfg_index_i  = dils_pkg::REG_SHORT_DELAY;
  logic [7:0] cfg_data_i   = 8'h00;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic [7:0] table_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] bus_byte_o;
  logic [7:0] delay_ms_o;
  logic [8:0] panel_width_o;
  logic [8:0] panel_height_o;
  logic       last_of_run_o;

  display_init_list_sequencer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .table_byte_i   (table_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .bus_byte_o     (bus_byte_o),
    .delay_ms_o     (delay_ms_o),
    .panel_width_o  (panel_width_o),
    .panel_height_o (panel_height_o),
    .last_of_run_o  (last_of_run_o)
  );

  always #2 clk_i = ~clk_i;

  // Table walker state mirrored on the bench side
  dils_pkg::cfg_t cfg_model = '{short_delay_ms: 8'd5, long_delay_ms: 8'd120,
                                access_control_code: 8'h36, sleep_out_code: 8'h11,
                                display_on_code: 8'h29};
  logic [1:0] walk_phase;
  logic [7:0] cmd_held;
  logic [6:0] args_remaining;
  logic       orient_arg_due;
  logic       delay_due;
  logic       axes_swapped;

  dils_pkg::result_t bus_events_due[$];
  logic [7:0]        table_bytes_pending[$];
  int                mismatches = 0;

  int                in_gap;
  bit                in_burst;
  int                out_hold;
  bit                out_burst;
  dils_pkg::result_t event_now;
  int                quiet_cycles = 0;

  function automatic logic [7:0] delay_for_held();
    if (cmd_held == cfg_model.sleep_out_code || cmd_held == cfg_model.display_on_code)
      return cfg_model.long_delay_ms;
    return cfg_model.short_delay_ms;
  endfunction

  function automatic void queue_bus_event(logic [1:0] kind, logic [7:0] bus,
                                          logic [7:0] dly);
    dils_pkg::result_t ev;
    ev.kind         = kind;
    ev.bus_byte     = bus;
    ev.delay_ms     = dly;
    ev.panel_width  = axes_swapped ? dils_pkg::PANEL_H : dils_pkg::PANEL_W;
    ev.panel_height = axes_swapped ? dils_pkg::PANEL_W : dils_pkg::PANEL_H;
    ev.last_of_run  = 1'b0;
    bus_events_due  = {bus_events_due, ev};
  endfunction

  // Advance the walker by one table byte and queue the bus events it causes
  function automatic void walk_table_byte(logic [7:0] b);
    int queued;
    queued = bus_events_due.size();
    case (walk_phase)
      dils_pkg::PH_CMD: begin
        if (b == TABLE_END_BYTE) begin
          walk_phase = dils_pkg::PH_DONE;
          queue_bus_event(dils_pkg::KIND_END, 8'h00, 8'h00);
        end else begin
          cmd_held   = b;
          walk_phase = dils_pkg::PH_COUNT;
          queue_bus_event(dils_pkg::KIND_CMD, b, 8'h00);
        end
      end
      dils_pkg::PH_COUNT: begin
        delay_due      = b[dils_pkg::COUNT_DELAY_BIT];
        args_remaining = b[6:0];
        if (args_remaining == 7'd0) begin
          orient_arg_due = 1'b0;
          walk_phase     = dils_pkg::PH_CMD;
          if (delay_due) begin
            queue_bus_event(dils_pkg::KIND_DELAY, 8'h00, delay_for_held());
            delay_due = 1'b0;
          end
        end else begin
          orient_arg_due = (cmd_held == cfg_model.access_control_code);
          walk_phase     = dils_pkg::PH_ARGS;
        end
      end
      dils_pkg::PH_ARGS: begin
        if (orient_arg_due) begin
          axes_swapped   = b[dils_pkg::SWAP_BIT];
          orient_arg_due = 1'b0;
        end
        queue_bus_event(dils_pkg::KIND_PARAM, b, 8'h00);
        args_remaining = args_remaining - 7'd1;
        if (args_remaining == 7'd0) begin
          walk_phase = dils_pkg::PH_CMD;
          if (delay_due) begin
            queue_bus_event(dils_pkg::KIND_DELAY, 8'h00, delay_for_held());
            delay_due = 1'b0;
          end
        end
      end
      default: ;
    endcase
    // Flag the final event of this byte
    if (bus_events_due.size() > queued)
      bus_events_due[bus_events_due.size() - 1].last_of_run = 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [8:0] want,
                             input logic [8:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Input driver: offer queued table bytes, idle a drawn number of cycles after each
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      table_byte_i   <= 8'h00;
      in_gap         = 0;
      in_burst       = 1'b0;
      walk_phase     = dils_pkg::PH_CMD;
      cmd_held       = 8'h00;
      args_remaining = 7'd0;
      orient_arg_due = 1'b0;
      delay_due      = 1'b0;
      axes_swapped   = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        walk_table_byte(table_byte_i);
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      // Hold a stalled transaction, otherwise load the next one or idle
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0 || table_bytes_pending.size() == 0) begin
          in_valid_i <= 1'b0;
          if (in_gap > 0) in_gap--;
        end else begin
          in_valid_i   <= 1'b1;
          table_byte_i <= table_bytes_pending.pop_front();
        end
      end
    end
  end

  // Output monitor: compare each transaction with the oldest due event, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_hold    = 0;
      out_burst   = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (bus_events_due.size() == 0) begin
          $error("unexpected result: kind %0d bus_byte %0d", kind_o, bus_byte_o);
          mismatches++;
        end else begin
          event_now = bus_events_due.pop_front();
          check_field("kind", 9'(event_now.kind), 9'(kind_o));
          check_field("bus_byte", 9'(event_now.bus_byte), 9'(bus_byte_o));
          check_field("delay_ms", 9'(event_now.delay_ms), 9'(delay_ms_o));
          check_field("panel_width", event_now.panel_width, panel_width_o);
          check_field("panel_height", event_now.panel_height, panel_height_o);
          check_field("last_of_run", 9'(event_now.last_of_run), 9'(last_of_run_o));
        end
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        out_hold = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (out_hold > 0) begin
        out_stall_i <= 1'b1;
        out_hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Drop the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic write_register(input logic [2:0] index, input logic [7:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    case (index)
      dils_pkg::REG_SHORT_DELAY: cfg_model.short_delay_ms      = value;
      dils_pkg::REG_LONG_DELAY:  cfg_model.long_delay_ms       = value;
      dils_pkg::REG_ACCESS_CTRL: cfg_model.access_control_code = value;
      dils_pkg::REG_SLEEP_OUT:   cfg_model.sleep_out_code      = value;
      dils_pkg::REG_DISPLAY_ON:  cfg_model.display_on_code     = value;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_all(input logic [7:0] short_ms, input logic [7:0] long_ms,
                             input logic [7:0] access, input logic [7:0] sleep_out,
                             input logic [7:0] display_on);
    write_register(dils_pkg::REG_SHORT_DELAY, short_ms);
    write_register(dils_pkg::REG_LONG_DELAY, long_ms);
    write_register(dils_pkg::REG_ACCESS_CTRL, access);
    write_register(dils_pkg::REG_SLEEP_OUT, sleep_out);
    write_register(dils_pkg::REG_DISPLAY_ON, display_on);
  endtask

  // Wait for every queued byte to go in and every due event to come out
  task automatic wait_until_idle();
    @(negedge clk_i);
    while (table_bytes_pending.size() != 0 || in_valid_i || out_valid_o ||
           bus_events_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Queue one record, favouring the configured command codes
  task automatic append_random_record(input bit max_args);
    logic [7:0] cmd;
    logic [6:0] nargs;
    logic       flag;
    case ($urandom_range(0, 4))
      0:       cmd = cfg_model.access_control_code;
      1:       cmd = cfg_model.sleep_out_code;
      2:       cmd = cfg_model.display_on_code;
      default: cmd = 8'($urandom_range(1, 255));
    endcase
    if (cmd == TABLE_END_BYTE) cmd = 8'($urandom_range(1, 255));
    flag = 1'($urandom_range(0, 1));
    if (max_args) nargs = 7'h7F;
    else if ($urandom_range(0, 59) == 0) nargs = 7'($urandom_range(5, 126));
    else nargs = 7'($urandom_range(0, 4));
    table_bytes_pending = {table_bytes_pending, cmd};
    table_bytes_pending = {table_bytes_pending, {flag, nargs}};
    repeat (nargs) table_bytes_pending = {table_bytes_pending, 8'($urandom)};
  endtask

  initial begin
    logic [7:0] opening [21];
    int         target;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Opening table: long and short delays, swap and unswap, empty records, byte extremes
    opening = '{cfg_model.sleep_out_code, 8'h80,
                8'hFF, 8'h00,
                cfg_model.access_control_code, 8'h82, 8'h20, 8'hFF,
                cfg_model.display_on_code, 8'h81, 8'h00,
                cfg_model.access_control_code, 8'h01, 8'hDF,
                8'h80, 8'h80,
                8'h01, 8'h03, 8'h55, 8'hAA, 8'h7F};
    foreach (opening[i]) table_bytes_pending = {table_bytes_pending, opening[i]};

    for (int phase_no = 0; phase_no < PHASE_COUNT; phase_no++) begin
      wait_until_idle();
      case (phase_no)
        1: program_all(8'h00, 8'hFF, 8'hFF, 8'h01, 8'h80);
        // all three codes coincide
        2: program_all(8'hFF, 8'h00, 8'h11, 8'h11, 8'h11);
        // access control never matches; sleep-out and display-on share a code
        3: program_all(8'($urandom), 8'($urandom), 8'h00, 8'hFF, 8'hFF);
        4, 5: program_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom));
        default: ;
      endcase
      if (phase_no == 3) append_random_record(1'b1);
      target = table_bytes_pending.size() + PHASE_BYTES;
      while (table_bytes_pending.size() < target) append_random_record(1'b0);
    end

    // Close the table, then feed bytes that must be dropped
    table_bytes_pending = {table_bytes_pending, TABLE_END_BYTE};
    table_bytes_pending = {table_bytes_pending, TABLE_END_BYTE};
    repeat (6) table_bytes_pending = {table_bytes_pending, 8'($urandom)};
    table_bytes_pending = {table_bytes_pending, 8'hFF};
    wait_until_idle();

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
src/dils_pkg.sv
src/dils_decode.sv
src/dils_queue.sv
src/display_init_list_sequencer.sv
bench/testbench.sv
